@@ rtl/core/gcm_pkg.sv @@
// ----------------------------------------------------------------------------
// gcm_pkg
// Types and constants shared by the greedy change maker pipeline.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int unsigned SLOT_COUNT  = 4;
  localparam int unsigned AMT_W       = 16;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned BITS_PER_ST = 2;
  localparam int unsigned ST_PER_SLOT = CNT_W / BITS_PER_ST;
  localparam int unsigned STAGES      = SLOT_COUNT * ST_PER_SLOT;

  localparam logic [2:0] REG_COINS_IN_USE = 3'd0;
  localparam logic [2:0] REG_COIN_VALUE_0 = 3'd1;
  localparam logic [2:0] REG_COIN_VALUE_1 = 3'd2;
  localparam logic [2:0] REG_COIN_VALUE_2 = 3'd3;
  localparam logic [2:0] REG_COIN_VALUE_3 = 3'd4;

  typedef struct packed {
    logic [AMT_W-1:0]                 rest;
    logic [SLOT_COUNT-1:0][CNT_W-1:0] stock;
    logic [SLOT_COUNT-1:0][CNT_W-1:0] used;
  } pipe_t;

endpackage

@@ rtl/core/greedy_change_maker.sv @@
// Each stage registers its result and settles two count bits.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits under out_stall.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// default denominations 1, 2, 5, 10 with four in use.
// ----------------------------------------------------------------------------
// greedy_change_maker
// Greedy change making with limited stock, as a 16-stage pipeline.
// ----------------------------------------------------------------------------
module greedy_change_maker #(
  parameter int unsigned MAX_COINS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_amount,
  input  logic [7:0]  in_stock_0,
  input  logic [7:0]  in_stock_1,
  input  logic [7:0]  in_stock_2,
  input  logic [7:0]  in_stock_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_change_ok,
  output logic [7:0]  out_used_0,
  output logic [7:0]  out_used_1,
  output logic [7:0]  out_used_2,
  output logic [7:0]  out_used_3,
  output logic [15:0] out_remainder
);
  import gcm_pkg::*;

  localparam int unsigned LIMIT = (MAX_COINS < SLOT_COUNT) ? MAX_COINS : SLOT_COUNT;

  logic [2:0]                       coins_in_use_r;
  logic [SLOT_COUNT-1:0][AMT_W-1:0] coin_value_r;
  logic [2:0]                       active;
  logic                             advance;
  logic  [STAGES:0]                 vld;
  pipe_t [STAGES:0]                 data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coins_in_use_r  <= 3'd4;
      coin_value_r[0] <= 16'd1;
      coin_value_r[1] <= 16'd2;
      coin_value_r[2] <= 16'd5;
      coin_value_r[3] <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COINS_IN_USE: coins_in_use_r  <= cfg_wdata[2:0];
        REG_COIN_VALUE_0: coin_value_r[0] <= cfg_wdata;
        REG_COIN_VALUE_1: coin_value_r[1] <= cfg_wdata;
        REG_COIN_VALUE_2: coin_value_r[2] <= cfg_wdata;
        REG_COIN_VALUE_3: coin_value_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign active = (coins_in_use_r > 3'(LIMIT)) ? 3'(LIMIT) : coins_in_use_r;

  // The pipeline moves as one; it holds only while a result is refused.
  assign advance  = !(vld[STAGES] && out_stall);
  assign in_stall = !advance;

  always_comb begin
    data[0]          = '0;
    data[0].rest     = in_amount;
    data[0].stock[0] = in_stock_0;
    data[0].stock[1] = in_stock_1;
    data[0].stock[2] = in_stock_2;
    data[0].stock[3] = in_stock_3;
  end
  assign vld[0] = in_valid;

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    localparam int unsigned SL = SLOT_COUNT - 1 - s / ST_PER_SLOT;
    localparam int unsigned BH = CNT_W - 1 - (s % ST_PER_SLOT) * BITS_PER_ST;
    logic en;
    assign en = (3'(SL) < active) && (coin_value_r[SL] != '0);
    gcm_stage #(.SLOT(SL), .BIT_HI(BH)) u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .slot_en    (en),
      .coin_value (coin_value_r[SL]),
      .in_vld     (vld[s]),
      .in_data    (data[s]),
      .out_vld    (vld[s+1]),
      .out_data   (data[s+1])
    );
  end

  assign out_valid     = vld[STAGES];
  assign out_change_ok = (data[STAGES].rest == '0);
  assign out_used_0    = data[STAGES].used[0];
  assign out_used_1    = data[STAGES].used[1];
  assign out_used_2    = data[STAGES].used[2];
  assign out_used_3    = data[STAGES].used[3];
  assign out_remainder = data[STAGES].rest;

endmodule

@@ rtl/core/gcm_stage.sv @@
// ----------------------------------------------------------------------------
// gcm_stage
// One pipeline stage: settles two count bits of one denomination.
// ----------------------------------------------------------------------------
module gcm_stage #(
  parameter int unsigned SLOT   = 3,
  parameter int unsigned BIT_HI = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          slot_en,
  input  logic [15:0]   coin_value,
  input  logic          in_vld,
  input  gcm_pkg::pipe_t in_data,
  output logic          out_vld,
  output gcm_pkg::pipe_t out_data
);
  import gcm_pkg::*;

  logic  vld_r;
  pipe_t data_r;
  pipe_t data_nxt;

  // Bitwise greedy search for the largest count that fits both the remaining
  // amount and the stock; the remaining amount is reduced as bits are kept.
  always_comb begin
    logic [CNT_W-1:0]       t;
    logic [CNT_W-1:0]       cand;
    logic [AMT_W+CNT_W-1:0] sh;
    data_nxt = in_data;
    t = in_data.used[SLOT];
    for (int i = 0; i < BITS_PER_ST; i++) begin
      cand = t | (CNT_W'(1) << (BIT_HI - i));
      sh   = (AMT_W+CNT_W)'(coin_value) << (BIT_HI - i);
      if (slot_en && (cand <= in_data.stock[SLOT]) &&
          (sh <= (AMT_W+CNT_W)'(data_nxt.rest))) begin
        data_nxt.rest = data_nxt.rest - sh[AMT_W-1:0];
        t = cand;
      end
    end
    data_nxt.used[SLOT] = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

@@ rtl/core/gcm_checker.sv @@
// ----------------------------------------------------------------------------
// gcm_checker
// Port-level checks for the greedy change maker.
// ----------------------------------------------------------------------------
module gcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_change_ok,
  input logic [15:0] out_remainder,
  input logic [7:0]  out_used_0
);

  // The success flag is exactly a zero remainder.
  a_ok_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_change_ok == (out_remainder == 16'd0)))
    else $error("change_ok disagrees with remainder");

  // The input side is held only while a result is refused.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a refused result");

  // A refused result stays and keeps its remainder and its first count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_remainder) &&
                                  $stable(out_used_0)))
    else $error("refused result changed");

  // A stalled request stays offered until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid)
    else $error("stalled request withdrawn");

endmodule

bind greedy_change_maker gcm_checker u_gcm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_change_ok (out_change_ok),
  .out_remainder (out_remainder),
  .out_used_0    (out_used_0)
);

@@ sim/tb_greedy_change_maker.sv @@
// ----------------------------------------------------------------------------
// tb_greedy_change_maker
// Self-checking bench for the greedy change maker. Each accepted request is
// run through a local model of the greedy pass with limited stock, and every
// result transfer is checked field by field against the oldest prediction.
// Denomination sets are varied between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_greedy_change_maker;
  import gcm_pkg::*;

  localparam int unsigned MODEL_MAX_COINS = 4;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic                             ok;
    logic [SLOT_COUNT-1:0][CNT_W-1:0] used;
    logic [AMT_W-1:0]                 rem;
  } change_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_amount;
  logic [7:0]  in_stock_0, in_stock_1, in_stock_2, in_stock_3;
  logic        out_valid;
  logic        out_stall;
  logic        out_change_ok;
  logic [7:0]  out_used_0, out_used_1, out_used_2, out_used_3;
  logic [15:0] out_remainder;

  // Local copy of the denomination registers.
  logic [2:0]  denom_count;
  logic [15:0] denom_value [SLOT_COUNT];

  change_t     pending_change [$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          gaps_on;
  bit          stalls_on;

  greedy_change_maker #(.MAX_COINS(MODEL_MAX_COINS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_amount(in_amount),
    .in_stock_0(in_stock_0), .in_stock_1(in_stock_1),
    .in_stock_2(in_stock_2), .in_stock_3(in_stock_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_change_ok(out_change_ok),
    .out_used_0(out_used_0), .out_used_1(out_used_1),
    .out_used_2(out_used_2), .out_used_3(out_used_3),
    .out_remainder(out_remainder)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic change_t greedy_payout(logic [15:0] amount,
                                            logic [SLOT_COUNT-1:0][7:0] stock);
    change_t     res;
    int unsigned rest;
    int unsigned active;
    int unsigned take;
    int unsigned slot;
    res    = '0;
    rest   = amount;
    active = denom_count;
    if (active > MODEL_MAX_COINS) active = MODEL_MAX_COINS;
    if (active > SLOT_COUNT) active = SLOT_COUNT;
    for (int k = active; k > 0 && rest > 0; k--) begin
      slot = k - 1;
      if (denom_value[slot] == 0 || stock[slot] == 0 || denom_value[slot] > rest)
        continue;
      take = rest / denom_value[slot];
      if (take > stock[slot]) take = stock[slot];
      res.used[slot] = take[7:0];
      rest -= take * denom_value[slot];
    end
    res.ok  = (rest == 0);
    res.rem = rest[15:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    error_count++;
  endtask

  // Result side: random stall bursts and the field-by-field check.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end

    if (rst_n && out_valid && !out_stall) begin
      if (pending_change.size() == 0) begin
        $display("result transfer with no request outstanding");
        error_count++;
      end else begin
        change_t want;
        want = pending_change.pop_front();
        if (out_change_ok !== want.ok) report_mismatch("change_ok", out_change_ok, want.ok);
        if (out_used_0 !== want.used[0]) report_mismatch("used_0", out_used_0, want.used[0]);
        if (out_used_1 !== want.used[1]) report_mismatch("used_1", out_used_1, want.used[1]);
        if (out_used_2 !== want.used[2]) report_mismatch("used_2", out_used_2, want.used[2]);
        if (out_used_3 !== want.used[3]) report_mismatch("used_3", out_used_3, want.used[3]);
        if (out_remainder !== want.rem) report_mismatch("remainder", out_remainder, want.rem);
      end
    end
  end

  // Watchdog: ends the run after a long stretch without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** greedy_change_maker: FAILED **");
      $finish;
    end
  end

  task automatic send_request(logic [15:0] amount, logic [SLOT_COUNT-1:0][7:0] stock);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_amount  <= amount;
    in_stock_0 <= stock[0];
    in_stock_1 <= stock[1];
    in_stock_2 <= stock[2];
    in_stock_3 <= stock[3];
    do @(posedge clk); while (in_stall);
    pending_change.push_back(greedy_payout(amount, stock));
  endtask

  // Lets the pipeline empty so registers can be rewritten safely.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_change.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (index == REG_COINS_IN_USE)
      denom_count = data[2:0];
    else if (index <= REG_COIN_VALUE_3)
      denom_value[2'(index - REG_COIN_VALUE_0)] = data;
    @(posedge clk);
  endtask

  task automatic set_denoms(logic [2:0] count, logic [15:0] v0, logic [15:0] v1,
                            logic [15:0] v2, logic [15:0] v3);
    drain_pipeline();
    write_reg(REG_COINS_IN_USE, {13'd0, count});
    write_reg(REG_COIN_VALUE_0, v0);
    write_reg(REG_COIN_VALUE_1, v1);
    write_reg(REG_COIN_VALUE_2, v2);
    write_reg(REG_COIN_VALUE_3, v3);
  endtask

  function automatic logic [SLOT_COUNT-1:0][7:0] random_stock();
    logic [SLOT_COUNT-1:0][7:0] s;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      case ($urandom_range(0, 5))
        0:       s[i] = 8'd0;
        1:       s[i] = 8'd255;
        2, 3:    s[i] = 8'($urandom_range(1, 6));
        default: s[i] = 8'($urandom_range(0, 255));
      endcase
    end
    return s;
  endfunction

  // Mostly amounts built from the current denominations, so that exact change
  // and partial payouts both occur often.
  function automatic logic [15:0] random_amount();
    int unsigned a;
    case ($urandom_range(0, 9))
      0, 1: a = $urandom_range(0, 65535);
      2:    a = $urandom_range(0, 40);
      default: begin
        a = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
          a += $urandom_range(0, 8) * denom_value[i];
        a += ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      end
    endcase
    return a[15:0];
  endfunction

  task automatic random_requests(int unsigned n);
    for (int i = 0; i < n; i++) send_request(random_amount(), random_stock());
  endtask

  task automatic test_reset_denominations();
    send_request(16'd0, {4{8'd255}});
    send_request(16'd65535, {4{8'd255}});
    send_request(16'd65535, {4{8'd0}});
    send_request(16'd37, {8'd2, 8'd1, 8'd3, 8'd4});
    send_request(16'd18, {8'd1, 8'd0, 8'd0, 8'd9});
    send_request(16'd1, {8'd0, 8'd5, 8'd5, 8'd5});
  endtask

  task automatic test_denomination_edges();
    // No slots in use: nothing is paid out.
    set_denoms(3'd0, 16'd1, 16'd2, 16'd5, 16'd10);
    send_request(16'd0, {4{8'd9}});
    send_request(16'd7, {4{8'd9}});
    // Counts above the slot limit saturate to four.
    set_denoms(3'd7, 16'd1, 16'd3, 16'd7, 16'd65535);
    send_request(16'd65535, {4{8'd255}});
    send_request(16'd65534, {4{8'd255}});
    set_denoms(3'd5, 16'd1, 16'd1, 16'd1, 16'd1);
    send_request(16'd600, {4{8'd255}});
    // Zero values are skipped, and out-of-order values still run top down.
    set_denoms(3'd4, 16'd0, 16'd50, 16'd0, 16'd3);
    send_request(16'd159, {4{8'd255}});
    set_denoms(3'd3, 16'd100, 16'd10, 16'd1, 16'd7);
    send_request(16'd345, {8'd2, 8'd4, 8'd40, 8'd9});
    set_denoms(3'd1, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
    send_request(16'd65535, {4{8'd1}});
    send_request(16'd65534, {4{8'd1}});
    // Writes to indexes past the last register are ignored.
    drain_pipeline();
    for (int idx = REG_COIN_VALUE_3 + 1; idx < 8; idx++) write_reg(idx[2:0], 16'hffff);
    send_request(16'd65535, {4{8'd255}});
    set_denoms(3'd2, 16'd1, 16'd2, 16'd5, 16'd10);
    send_request(16'd600, {8'd255, 8'd255, 8'd255, 8'd255});
  endtask

  task automatic test_random_denominations();
    logic [15:0] v [SLOT_COUNT];
    for (int phase = 0; phase < 16; phase++) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        case ($urandom_range(0, 9))
          0:       v[i] = 16'd0;
          1:       v[i] = 16'($urandom_range(0, 65535));
          default: v[i] = 16'((i == 0 ? 16'd0 : v[i-1]) + $urandom_range(1, 40));
        endcase
      end
      set_denoms(3'($urandom_range(0, 7)), v[0], v[1], v[2], v[3]);
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      random_requests(100);
    end
  endtask

  task automatic test_full_rate();
    set_denoms(3'd4, 16'd1, 16'd5, 16'd25, 16'd100);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_requests(200);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_amount   = '0;
    in_stock_0  = '0;
    in_stock_1  = '0;
    in_stock_2  = '0;
    in_stock_3  = '0;
    out_stall   = 1'b0;
    stall_left  = 0;
    error_count = 0;
    quiet_cycles = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    denom_count = 3'd4;
    denom_value = '{16'd1, 16'd2, 16'd5, 16'd10};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_denominations();
    test_denomination_edges();
    test_random_denominations();
    test_full_rate();
    drain_pipeline();

    if (error_count == 0)
      $display("** greedy_change_maker: PASSED **");
    else
      $display("** greedy_change_maker: FAILED **");
    $finish;
  end

endmodule

@@ greedy_change_maker.f @@
rtl/core/gcm_pkg.sv
rtl/core/gcm_stage.sv
rtl/core/greedy_change_maker.sv
rtl/core/gcm_checker.sv
sim/tb_greedy_change_maker.sv
